// ===== hw/rtl/ps2md_pkg.sv =====
`default_nettype none

package ps2md_pkg;

	localparam logic [1:0] MODE_STANDARD = 2'd0;
	localparam logic [1:0] MODE_SCROLL   = 2'd1;
	localparam logic [1:0] MODE_BUTTONS  = 2'd2;

	localparam logic [1:0] REG_PACKET_MODE = 2'd0;
	localparam logic [1:0] REG_X_LIMIT     = 2'd1;
	localparam logic [1:0] REG_Y_LIMIT     = 2'd2;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_X      = 2'd1;
	localparam logic [1:0] PH_Y      = 2'd2;
	localparam logic [1:0] PH_FOURTH = 2'd3;

	localparam int SYNC_BIT = 3;

	localparam logic [11:0] X_LIMIT_RST = 12'd600;
	localparam logic [11:0] Y_LIMIT_RST = 12'd400;

	typedef struct packed {
		logic [1:0]  packet_mode;
		logic [11:0] x_limit;
		logic [11:0] y_limit;
	} cfg_t;

	// packed so that delta_x lands in the low bits of the output tdata
	typedef struct packed {
		logic [11:0]       pointer_y;
		logic [11:0]       pointer_x;
		logic              wheel_up;
		logic              wheel_down;
		logic              middle_pressed;
		logic              right_pressed;
		logic              left_pressed;
		logic signed [9:0] delta_y;
		logic signed [8:0] delta_x;
	} res_t;

	// pos + delta, clamped to [0, limit]
	function automatic logic [11:0] clamp_pos(input logic [11:0] pos,
		input logic signed [13:0] delta, input logic [11:0] limit);
		logic signed [13:0] sum;
		logic [11:0]        r;
		sum = $signed({2'b00, pos}) + delta;
		if (sum[13]) begin
			r = '0;
		end else if (sum[12:0] > {1'b0, limit}) begin
			r = limit;
		end else begin
			r = sum[11:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ps2md_cfg.sv =====
`default_nettype none

module ps2md_cfg
	import ps2md_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [11:0] wr_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.packet_mode <= MODE_STANDARD;
			cfg_q.x_limit     <= X_LIMIT_RST;
			cfg_q.y_limit     <= Y_LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_PACKET_MODE: cfg_q.packet_mode <= wr_data[1:0];
				REG_X_LIMIT:     cfg_q.x_limit     <= wr_data;
				REG_Y_LIMIT:     cfg_q.y_limit     <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ps2md_core.sv =====
`default_nettype none

module ps2md_core
	import ps2md_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic [7:0] rx_byte,
	input  wire cfg_t       cfg,
	output logic            res_valid,
	output res_t            res
);

	logic [1:0]  phase_q;
	logic [7:0]  header_q;
	logic [7:0]  xbyte_q;
	logic [7:0]  ybyte_q;
	logic [11:0] posx_q;
	logic [11:0] posy_q;

	logic              four_byte;
	logic              finish;
	logic [7:0]        y_cur;
	logic [7:0]        fourth;
	logic              ovf;
	logic [1:0]        phase_nxt;
	logic signed [8:0] dx;
	logic signed [9:0] dy;
	logic [11:0]       new_x;
	logic [11:0]       new_y;

	assign four_byte = (cfg.packet_mode == MODE_SCROLL) || (cfg.packet_mode == MODE_BUTTONS);
	assign finish    = ((phase_q == PH_Y) && !four_byte) || (phase_q == PH_FOURTH);
	assign y_cur     = (phase_q == PH_Y) ? rx_byte : ybyte_q;
	assign fourth    = (phase_q == PH_FOURTH) ? rx_byte : 8'h00;
	assign ovf       = |header_q[7:6];

	// header bit 4/5 are the ninth (sign) bits; Y is negated so down is positive
	assign dx = $signed({header_q[4], xbyte_q});
	assign dy = -$signed({header_q[5], header_q[5], y_cur});

	assign new_x = clamp_pos(posx_q, 14'(dx), cfg.x_limit);
	assign new_y = clamp_pos(posy_q, 14'(dy), cfg.y_limit);

	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			PH_HEADER: phase_nxt = rx_byte[SYNC_BIT] ? PH_X : PH_HEADER;
			PH_X:      phase_nxt = PH_Y;
			PH_Y:      phase_nxt = four_byte ? PH_FOURTH : PH_HEADER;
			PH_FOURTH: phase_nxt = PH_HEADER;
			default:   phase_nxt = PH_HEADER;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			posx_q  <= '0;
			posy_q  <= '0;
		end else if (en) begin
			phase_q <= phase_nxt;
			if (finish && !ovf) begin
				posx_q <= new_x;
				posy_q <= new_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (phase_q)
				PH_HEADER: header_q <= rx_byte;
				PH_X:      xbyte_q  <= rx_byte;
				PH_Y:      ybyte_q  <= rx_byte;
				default: ;
			endcase
		end
	end

	assign res_valid = finish && !ovf;

	always_comb begin
		res.delta_x        = dx;
		res.delta_y        = dy;
		res.left_pressed   = header_q[0];
		res.right_pressed  = header_q[1];
		res.middle_pressed = header_q[2];
		res.wheel_down     = (cfg.packet_mode == MODE_SCROLL) && (fourth != 8'h00) && !fourth[7];
		res.wheel_up       = (cfg.packet_mode == MODE_SCROLL) && fourth[7];
		res.pointer_x      = new_x;
		res.pointer_y      = new_y;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ps2_mouse_packet_decoder_top.sv =====
// Channel   | Dir | Handshake              | Payload
// s_*       | in  | s_tvalid / s_tready    | s_tdata: rx_byte
// m_*       | out | m_tvalid / m_tready    | m_tdata: decoded packet item
// cfg_*     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One byte is accepted per cycle while s_tready is high. Each byte waits in the
// input register until the decode/accumulate logic takes it; a packet's last
// byte then writes the packet item into the result register, which drives m_*
// until the item is taken.
// Only the result register backpressures: while it is full and not taken, a
// byte in the input register holds, s_tready drops. cfg_ready is always high.
// arst_n clears packet phase, pointer position and valid flags; the limits
// reset to 600 and 400 and the mode to standard three-byte.
`default_nettype none

module ps2_mouse_packet_decoder_top
	import ps2md_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte

	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [8:0] delta_x, [18:9] delta_y, [19] left_pressed,
	                                    // [20] right_pressed, [21] middle_pressed,
	                                    // [22] wheel_down, [23] wheel_up,
	                                    // [35:24] pointer_x, [47:36] pointer_y

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);

	cfg_t cfg;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic       out_valid_q;
	res_t       out_q;

	logic advance;
	logic core_en;
	logic res_valid;
	res_t res;

	// the stage can move whenever the result register is empty or being drained
	assign advance  = !out_valid_q || m_tready;
	assign core_en  = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	assign cfg_ready = 1'b1;

	ps2md_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	ps2md_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (core_en),
		.rx_byte   (byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// bytes that end no packet (header, X, and Y in four-byte modes) and dropped packets leave the result register empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= core_en && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_en && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ps2md_checker.sv =====
`default_nettype none

module ps2md_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata
);

	// a stalled item stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	// wheel flags are mutually exclusive
	a_wheel_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[22] && m_tdata[23]))
		else $error("wheel up and down both set");

	// inverted Y delta can never reach -256
	a_dy_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[18:9] != 10'h300)
		else $error("delta_y out of range");

	// a fresh item needs an earlier accepted byte, passed through the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("output item without a preceding input byte");

endmodule

bind ps2_mouse_packet_decoder_top ps2md_checker u_ps2md_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import ps2md_pkg::*;

	// index 3 is decoded by nothing: a write there must leave every register alone
	localparam logic [1:0] REG_UNUSED     = 2'd3;
	localparam logic [1:0] MODE_UNDEFINED = 2'd3;

	// cycles to let the two-stage pipe empty when the last bytes made no item
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_BYTES   = 170;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

	// one line of the directed script: a byte to send, or a register write
	typedef struct {
		row_kind_e   kind;
		logic [7:0]  rx;
		logic [1:0]  idx;
		logic [11:0] data;
		bit          typed;   // want holds a hand-written packet item
		res_t        want;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;     // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;     // [8:0] delta_x, [18:9] delta_y, [19] left_pressed,
	                          // [20] right_pressed, [21] middle_pressed,
	                          // [22] wheel_down, [23] wheel_up,
	                          // [35:24] pointer_x, [47:36] pointer_y
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [11:0] cfg_data;

	ps2_mouse_packet_decoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 20 ns period, low then high
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Decoder shadow: config and packet state, updated per accepted item
	// ---------------------------------------------------------------
	logic [1:0]  cur_mode;
	logic [11:0] cur_xlim;
	logic [11:0] cur_ylim;
	logic [1:0]  pk_phase;
	logic [7:0]  pk_header;
	logic [7:0]  pk_x;
	logic [7:0]  pk_y;
	logic [11:0] ptr_x;
	logic [11:0] ptr_y;

	res_t        expected_packets[$];
	script_row_t script[$];
	int          errors;
	int          rx_sent;
	int          stall_left;
	bit          no_idle;      // set for stretches with both sides at full rate
	res_t        mon_got;
	res_t        mon_want;

	// Feeds one byte to the shadow decoder; returns 1 when it completes a
	// packet that yields an item, with that item in pkt.
	function automatic bit decode_rx_byte(input logic [7:0] b, output res_t pkt);
		bit                done;
		logic [7:0]        fourth;
		logic signed [8:0] dx;
		logic signed [9:0] dy;
		int                nx;
		int                ny;
		done   = 1'b0;
		fourth = '0;
		pkt    = '0;
		case (pk_phase)
			PH_HEADER: begin
				// bytes without the sync bit are thrown away here
				pk_header = b;
				if (b[SYNC_BIT])
					pk_phase = PH_X;
			end
			PH_X: begin
				pk_x     = b;
				pk_phase = PH_Y;
			end
			PH_Y: begin
				// mode sampled here decides whether a fourth byte follows
				pk_y = b;
				if (cur_mode == MODE_SCROLL || cur_mode == MODE_BUTTONS)
					pk_phase = PH_FOURTH;
				else
					done = 1'b1;
			end
			default: begin
				fourth = b;
				done   = 1'b1;
			end
		endcase
		if (!done)
			return 1'b0;
		pk_phase = PH_HEADER;
		// either overflow bit drops the whole packet, position untouched
		if (pk_header[7:6] != 2'b00)
			return 1'b0;
		dx = $signed({pk_header[4], pk_x});
		dy = -$signed({pk_header[5], pk_header[5], pk_y});
		nx = int'(ptr_x) + int'(dx);
		ny = int'(ptr_y) + int'(dy);
		if (nx < 0) nx = 0;
		if (nx > int'(cur_xlim)) nx = int'(cur_xlim);
		if (ny < 0) ny = 0;
		if (ny > int'(cur_ylim)) ny = int'(cur_ylim);
		ptr_x = nx[11:0];
		ptr_y = ny[11:0];
		pkt.delta_x        = dx;
		pkt.delta_y        = dy;
		pkt.left_pressed   = pk_header[0];
		pkt.right_pressed  = pk_header[1];
		pkt.middle_pressed = pk_header[2];
		// wheel reads mode again at packet end; zero byte means no scroll
		pkt.wheel_up   = (cur_mode == MODE_SCROLL) && (fourth != 8'h00) && fourth[7];
		pkt.wheel_down = (cur_mode == MODE_SCROLL) && (fourth != 8'h00) && !fourth[7];
		pkt.pointer_x  = ptr_x;
		pkt.pointer_y  = ptr_y;
		return 1'b1;
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic res_t mk_res(input int dx, input int dy, input bit l, input bit r,
		input bit m, input bit dn, input bit up, input int px, input int py);
		res_t v;
		v.delta_x        = dx[8:0];
		v.delta_y        = dy[9:0];
		v.left_pressed   = l;
		v.right_pressed  = r;
		v.middle_pressed = m;
		v.wheel_down     = dn;
		v.wheel_up       = up;
		v.pointer_x      = px[11:0];
		v.pointer_y      = py[11:0];
		return v;
	endfunction

	// ---------------------------------------------------------------
	// Script building
	// ---------------------------------------------------------------
	task automatic add_rx(input logic [7:0] b);
		script_row_t row;
		row = '{kind: ROW_BYTE, rx: b, idx: '0, data: '0, typed: 1'b0, want: '0};
		script.push_back(row);
	endtask

	task automatic add_rx_want(input logic [7:0] b, input res_t want);
		script_row_t row;
		row = '{kind: ROW_BYTE, rx: b, idx: '0, data: '0, typed: 1'b1, want: want};
		script.push_back(row);
	endtask

	task automatic add_cfg(input logic [1:0] idx, input logic [11:0] data);
		script_row_t row;
		row = '{kind: ROW_CFG, rx: '0, idx: idx, data: data, typed: 1'b0, want: '0};
		script.push_back(row);
	endtask

	// ---------------------------------------------------------------
	// Drivers: inputs move on the falling edge, handshakes seen on rising
	// ---------------------------------------------------------------

	// Offers one byte after a random gap and waits for it to be taken.
	// The shadow decoder runs at the accepting edge, so expectations are
	// queued well before the item leaves the pipe.
	task automatic push_byte(input logic [7:0] b, input bit typed, input res_t want);
		res_t pkt;
		bit   made;
		int   gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		made = decode_rx_byte(b, pkt);
		if (made)
			expected_packets.push_back(typed ? want : pkt);
		rx_sent++;
	endtask

	// Stops sending until every queued item is out and the pipe is empty.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_packets.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write, only ever with the decoder idle.
	task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PACKET_MODE: cur_mode = data[1:0];
			REG_X_LIMIT:     cur_xlim = data;
			REG_Y_LIMIT:     cur_ylim = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_fourth();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'h80;
			2:       return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	// Well-formed packet with random content; now and then the mode is
	// changed between bytes to hit the mid-packet sampling points.
	task automatic random_packet();
		logic [7:0] hdr;
		hdr = 8'($urandom);
		hdr[SYNC_BIT] = 1'b1;
		if ($urandom_range(0, 9) != 0)
			hdr[7:6] = 2'b00;
		push_byte(hdr, 1'b0, '0);
		push_byte(8'($urandom), 1'b0, '0);
		if ($urandom_range(0, 39) == 0)
			write_reg(REG_PACKET_MODE, {10'($urandom), 2'($urandom)});
		push_byte(8'($urandom), 1'b0, '0);
		if (cur_mode == MODE_SCROLL || cur_mode == MODE_BUTTONS) begin
			if ($urandom_range(0, 39) == 0)
				write_reg(REG_PACKET_MODE, {10'($urandom), 2'($urandom)});
			push_byte(pick_fourth(), 1'b0, '0);
		end
	endtask

	// ---------------------------------------------------------------
	// Result side: random backpressure
	// ---------------------------------------------------------------
	initial begin
		m_tready   = 1'b0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready   <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// every accepted item is matched against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			mon_got = res_t'(m_tdata);
			if (expected_packets.size() == 0) begin
				$error("packet item with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				mon_want = expected_packets.pop_front();
				check_field("delta_x", int'(mon_want.delta_x), int'(mon_got.delta_x));
				check_field("delta_y", int'(mon_want.delta_y), int'(mon_got.delta_y));
				check_field("left_pressed", mon_want.left_pressed, mon_got.left_pressed);
				check_field("right_pressed", mon_want.right_pressed, mon_got.right_pressed);
				check_field("middle_pressed", mon_want.middle_pressed,
					mon_got.middle_pressed);
				check_field("wheel_down", mon_want.wheel_down, mon_got.wheel_down);
				check_field("wheel_up", mon_want.wheel_up, mon_got.wheel_up);
				check_field("pointer_x", mon_want.pointer_x, mon_got.pointer_x);
				check_field("pointer_y", mon_want.pointer_y, mon_got.pointer_y);
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		errors    = 0;
		rx_sent   = 0;
		no_idle   = 1'b0;

		// shadow state matches the block after reset
		cur_mode  = MODE_STANDARD;
		cur_xlim  = X_LIMIT_RST;
		cur_ylim  = Y_LIMIT_RST;
		pk_phase  = PH_HEADER;
		pk_header = '0;
		pk_x      = '0;
		pk_y      = '0;
		ptr_x     = '0;
		ptr_y     = '0;

		// --- directed script ---
		// header without sync bit: dropped, still hunting
		add_rx(8'h00);
		// all buttons, largest positive X, from the reset position
		add_rx(8'h0F);
		add_rx(8'hFF);
		add_rx_want(8'h00, mk_res(255, 0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 255, 0));
		// both sign bits, zero bytes: most negative X, largest downward Y;
		// X clamps at zero
		add_rx(8'h38);
		add_rx(8'h00);
		add_rx_want(8'h00, mk_res(-256, 256, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 0, 256));
		// both overflow bits: no item, position kept
		add_rx(8'hC8);
		add_rx(8'h7F);
		add_rx(8'h7F);
		// scroll mode: positive, negative and zero wheel bytes
		add_cfg(REG_PACKET_MODE, {10'd0, MODE_SCROLL});
		add_rx(8'h09);
		add_rx(8'h01);
		add_rx(8'hFF);
		add_rx(8'h7F);
		add_rx(8'h0A);
		add_rx(8'h00);
		add_rx(8'h00);
		add_rx(8'h80);
		add_rx(8'h08);
		add_rx(8'h00);
		add_rx(8'h00);
		add_rx(8'h00);
		// mode dropped to standard before the Y byte: packet ends at three
		add_rx(8'h08);
		add_rx(8'h05);
		add_cfg(REG_PACKET_MODE, {10'd0, MODE_STANDARD});
		add_rx(8'h05);
		// extra-button mode, switched to scroll before the fourth byte
		add_cfg(REG_PACKET_MODE, {10'd0, MODE_BUTTONS});
		add_rx(8'h0C);
		add_rx(8'h10);
		add_rx(8'h10);
		add_cfg(REG_PACKET_MODE, {10'd0, MODE_SCROLL});
		add_rx(8'hFF);
		// undefined mode acts as standard; limits at both extremes
		add_cfg(REG_PACKET_MODE, {10'h3FF, MODE_UNDEFINED});
		add_cfg(REG_X_LIMIT, 12'd0);
		add_cfg(REG_Y_LIMIT, 12'hFFF);
		add_cfg(REG_UNUSED, 12'hFFF);
		add_rx(8'h08);
		add_rx(8'hFF);
		add_rx(8'h80);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG)
				write_reg(script[i].idx, script[i].data);
			else
				push_byte(script[i].rx, script[i].typed, script[i].want);
		end

		// --- random phases, each with its own register setting ---
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_reg(REG_PACKET_MODE, {10'($urandom), 2'(p)});
			case (p)
				0: begin
					write_reg(REG_X_LIMIT, 12'hFFF);
					write_reg(REG_Y_LIMIT, 12'hFFF);
				end
				1: begin
					write_reg(REG_X_LIMIT, 12'd0);
					write_reg(REG_Y_LIMIT, 12'd0);
				end
				2: begin
					write_reg(REG_X_LIMIT, 12'hFFF);
					write_reg(REG_Y_LIMIT, 12'd0);
				end
				default: begin
					write_reg(REG_X_LIMIT, 12'($urandom_range(0, 4095)));
					write_reg(REG_Y_LIMIT, 12'($urandom_range(0, 1023)));
				end
			endcase
			// one phase runs at full rate on both sides
			no_idle = (p == 3);
			for (int n = 0; n < PHASE_BYTES; ) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: stray bytes that may break sync
					repeat ($urandom_range(1, 3)) begin
						push_byte(8'($urandom), 1'b0, '0);
						n++;
					end
				end else begin
					n += (cur_mode == MODE_SCROLL || cur_mode == MODE_BUTTONS) ? 4 : 3;
					random_packet();
				end
				// sender holds until the pipe has fully drained
				if ($urandom_range(0, 49) == 0)
					settle();
				// X limit set to a random value in [0, 63] mid-phase
				if (n >= PHASE_BYTES / 2 && n < PHASE_BYTES / 2 + 4)
					write_reg(REG_X_LIMIT, 12'($urandom_range(0, 63)));
			end
			no_idle = 1'b0;
		end

		settle();
		if (errors == 0)
			$display("PASS ps2_mouse_packet_decoder_top");
		else
			$display("FAIL ps2_mouse_packet_decoder_top");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#12_000_000;
		$display("FAIL ps2_mouse_packet_decoder_top");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/ps2md_pkg.sv
hw/rtl/ps2md_cfg.sv
hw/rtl/ps2md_core.sv
hw/rtl/ps2_mouse_packet_decoder_top.sv
hw/rtl/ps2md_checker.sv
sim/testbench.sv
